// ----- hdl/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the button press classifier: state and event
// codes, the per-button memory entry and the register map.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Field widths of the stream items, registers and memory entry
  localparam int unsigned IdxW   = 2;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CountW = 2;

  // Per-button state machine
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DEBOUNCE = 3'd1,
    ST_PRESSED  = 3'd2,
    ST_SHORT    = 3'd3,
    ST_LONG     = 3'd4,
    ST_LONG_REL = 3'd5,
    ST_SINGLE   = 3'd6,
    ST_DOUBLE   = 3'd7
  } state_e;

  // Event codes reported with each result
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_SINGLE   = 3'd1,
    EV_DOUBLE   = 3'd2,
    EV_LONG     = 3'd3,
    EV_LONG_REL = 3'd4
  } event_e;

  // Register indexes (byte address 4*index)
  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_DOUBLE_GAP = 2'd2
  } reg_idx_e;

  localparam logic [CfgW-1:0] DebounceRst  = 16'd10;
  localparam logic [CfgW-1:0] LongPressRst = 16'd300;
  localparam logic [CfgW-1:0] DoubleGapRst = 16'd20;

  localparam logic [CountW-1:0] CountMax = 2'd3;

  // One memory entry per button; all-zero is the reset value
  typedef struct packed {
    state_e              fsm;
    logic [TimeW-1:0]    state_start;
    logic [TimeW-1:0]    press_start;
    logic [CountW-1:0]   count;
  } entry_t;

endpackage

// ----- hdl/button_press_classifier.sv -----
// A poll is captured in stage 1 and its result loaded into the output register
// when that is free or draining. One poll per cycle unless the output stalls; the
// memory read at acceptance and write-back at stage 1 exit, with forwarding, set the pace.
// Reset clears the pipeline valids, the per-entry valid bits (an entry not yet
// written reads as idle with zero times and count) and reloads the registers.
// The state memory itself is not swept, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
// button_press_classifier
// Debounces polled buttons and classifies single, double and long presses,
// holding each button's state machine in a read-modify-write memory.
// ----------------------------------------------------------------------------
module button_press_classifier #(
  parameter int unsigned NUM_BUTTONS = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Poll stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // button_index[1:0], pin_level[2], time_ms[34:3]
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // button_id[1:0], event_code[4:2], fsm_state[7:5]
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bpc_pkg::*;

  localparam int unsigned AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [CfgW-1:0] debounce_q, long_press_q, double_gap_q;
  logic            cfg_wr;
  reg_idx_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  // Write a register on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceRst;
      long_press_q <= LongPressRst;
      double_gap_q <= DoubleGapRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DEBOUNCE:   debounce_q   <= pwdata[CfgW-1:0];
        REG_LONG_PRESS: long_press_q <= pwdata[CfgW-1:0];
        REG_DOUBLE_GAP: double_gap_q <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_DEBOUNCE:   prdata = {16'b0, debounce_q};
      REG_LONG_PRESS: prdata = {16'b0, long_press_q};
      REG_DOUBLE_GAP: prdata = {16'b0, double_gap_q};
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  logic [IdxW-1:0]  in_idx;
  logic [AW-1:0]    in_addr;
  logic             in_inr;
  logic             s_accept;

  assign in_idx   = s_axis_tdata[1:0];
  assign in_addr  = AW'(in_idx);
  assign in_inr   = 32'(in_idx) < NUM_BUTTONS;
  assign s_accept = s_axis_tvalid & s_axis_tready;

  // --------------------------------------------------------------------------
  // Stage 1: memory read data and poll fields
  // --------------------------------------------------------------------------
  logic             s1_v_q;
  logic [IdxW-1:0]  s1_idx_q;
  logic             s1_pin_q;
  logic [TimeW-1:0] s1_time_q;
  logic             s1_inr_q;
  logic [AW-1:0]    s1_addr_q;
  entry_t           rd_q;
  logic             rd_vld_q;
  logic             fwd_hit_q;
  entry_t           fwd_q;

  logic             out_v_q;
  logic [7:0]       out_q;
  logic             adv1;

  entry_t           mem_q [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] valid_q;

  entry_t           cur;
  entry_t           nxt;
  event_e           ev;
  logic             pressed;
  logic [TimeW-1:0] gap_s, gap_p;

  // Stage 1 moves on when the output register is free or being drained
  assign adv1          = s1_v_q & (~out_v_q | m_axis_tready);
  assign s_axis_tready = ~s1_v_q | adv1;

  // Stage 1 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s_accept) begin
      s1_v_q <= 1'b1;
    end else if (adv1) begin
      s1_v_q <= 1'b0;
    end
  end

  // Capture the poll, read its entry and note a write-back to the same entry
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_idx_q  <= in_idx;
      s1_pin_q  <= s_axis_tdata[2];
      s1_time_q <= s_axis_tdata[34:3];
      s1_inr_q  <= in_inr;
      s1_addr_q <= in_addr;
      fwd_hit_q <= adv1 & s1_inr_q & in_inr & (s1_addr_q == in_addr);
      fwd_q     <= nxt;
      if (in_inr) begin
        rd_q     <= mem_q[in_addr];
        rd_vld_q <= valid_q[in_addr];
      end else begin
        rd_vld_q <= 1'b0;
      end
    end
  end

  // Write back the updated entry as the poll leaves stage 1
  always_ff @(posedge clk_i) begin
    if (adv1 && s1_inr_q) begin
      mem_q[s1_addr_q] <= nxt;
    end
  end

  // Mark entries as written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv1 && s1_inr_q) begin
      valid_q[s1_addr_q] <= 1'b1;
    end
  end

  // Pick forwarded, stored or reset entry
  always_comb begin
    if (fwd_hit_q) begin
      cur = fwd_q;
    end else if (rd_vld_q) begin
      cur = rd_q;
    end else begin
      cur = '0;
    end
  end

  // --------------------------------------------------------------------------
  // State update
  // --------------------------------------------------------------------------
  assign pressed = ~s1_pin_q;
  assign gap_s   = s1_time_q - cur.state_start;
  assign gap_p   = s1_time_q - cur.press_start;

  always_comb begin
    nxt = cur;
    ev  = EV_NONE;
    case (cur.fsm)
      ST_IDLE: begin
        nxt.count = '0;
        if (pressed) begin
          nxt.fsm         = ST_DEBOUNCE;
          nxt.state_start = s1_time_q;
        end
      end
      ST_DEBOUNCE: begin
        if (gap_s > TimeW'(debounce_q)) begin
          if (pressed) begin
            nxt.fsm         = ST_PRESSED;
            nxt.press_start = s1_time_q;
          end else begin
            nxt.fsm = ST_IDLE;
          end
        end
      end
      ST_PRESSED: begin
        if (!pressed) begin
          if (cur.count != CountMax) begin
            nxt.count = cur.count + 2'd1;
          end
          nxt.fsm         = ST_SHORT;
          nxt.state_start = s1_time_q;
        end else if (gap_p > TimeW'(long_press_q)) begin
          ev      = EV_LONG;
          nxt.fsm = ST_LONG;
        end
      end
      ST_SHORT: begin
        if (pressed && (gap_s > TimeW'(debounce_q))) begin
          nxt.fsm         = ST_DEBOUNCE;
          nxt.state_start = s1_time_q;
        end else if (gap_s > TimeW'(double_gap_q)) begin
          if (cur.count == 2'd1) begin
            nxt.fsm = ST_SINGLE;
          end else if (cur.count > 2'd1) begin
            nxt.fsm = ST_DOUBLE;
          end
        end
      end
      ST_LONG: begin
        if (!pressed) begin
          nxt.fsm = ST_LONG_REL;
        end
      end
      ST_LONG_REL: begin
        ev      = EV_LONG_REL;
        nxt.fsm = ST_IDLE;
      end
      ST_SINGLE: begin
        ev      = EV_SINGLE;
        nxt.fsm = ST_IDLE;
      end
      ST_DOUBLE: begin
        ev      = EV_DOUBLE;
        nxt.fsm = ST_IDLE;
      end
      default: begin
        nxt.fsm = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv1) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  // Load the result; an out-of-range index reports idle with no event
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      if (s1_inr_q) begin
        out_q <= {nxt.fsm, ev, s1_idx_q};
      end else begin
        out_q <= {ST_IDLE, EV_NONE, s1_idx_q};
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule

// ----- hdl/bpc_checker.sv -----
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks of the button press classifier, bound to the top level.
// ----------------------------------------------------------------------------
module bpc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tready,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready
);
  import bpc_pkg::*;

  logic cfg_wr;
  logic in_map;

  assign cfg_wr = psel & penable & pwrite & pready;
  assign in_map = paddr[3:2] != 2'd3;

  // A stalled result holds its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Input back-pressure only while a result is pending
  a_ready_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // A written register reads back its new value
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && in_map ##1 (paddr == $past(paddr)) && !cfg_wr |->
      prdata[15:0] == $past(pwdata[15:0]))
    else $error("register readback mismatch");

  // Registers are 16 bits wide
  a_read_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> prdata[31:16] == 16'b0)
    else $error("register upper bits not zero");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);
